>>> hw/rtl/asgr_pkg.sv
// Shared types and the SGR color table for the ANSI SGR color parser.
// No dependencies; used by asgr_parser, asgr_outq and the top level.
`timescale 1ns / 1ps

package asgr_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned ColorW = 32;
	localparam int unsigned CodeW  = 10;

	localparam logic [ColorW-1:0] COLOR_WHITE = 32'hFFFF_FFFF;

	// One result: a byte to draw, its color and the end-of-request mark
	typedef struct packed {
		logic [CharW-1:0]  ch;
		logic [ColorW-1:0] color;
		logic              last;
	} asgr_res_t;

	// Results caused by one input byte (zero, one or two)
	typedef struct packed {
		logic [1:0] cnt;
		asgr_res_t  res0;
		asgr_res_t  res1;
	} asgr_push_t;

	// SGR foreground code to ARGB; anything not listed gives white
	function automatic logic [ColorW-1:0] sgr_color(input logic [CodeW-1:0] code);
		logic [ColorW-1:0] c;
		c = COLOR_WHITE;
		unique case (code)
			10'd30:  c = 32'hFF11_1111;
			10'd31:  c = 32'hFFFF_5555;
			10'd32:  c = 32'hFF55_FF55;
			10'd33:  c = 32'hFFFF_FF55;
			10'd34:  c = 32'hFF55_55FF;
			10'd35:  c = 32'hFFFF_55FF;
			10'd36:  c = 32'hFF55_FFFF;
			10'd90:  c = 32'hFF88_8888;
			10'd91:  c = 32'hFFFF_8888;
			10'd92:  c = 32'hFF88_FF88;
			10'd93:  c = 32'hFFFF_FF88;
			10'd94:  c = 32'hFF88_88FF;
			10'd95:  c = 32'hFFFF_88FF;
			10'd96:  c = 32'hFF88_FFFF;
			default: c = COLOR_WHITE;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/asgr_parser.sv
// Escape sequence state machine: mode, SGR parameter and current color.
// Depends on asgr_pkg for the result types and the color table.
`timescale 1ns / 1ps

module asgr_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [asgr_pkg::CharW-1:0] ch,
	input  logic                     fire,
	output asgr_pkg::asgr_push_t     push
);
	import asgr_pkg::*;

	localparam logic [CharW-1:0] CHAR_ESC  = 8'h1B;
	localparam logic [CharW-1:0] CHAR_LBRK = 8'h5B;
	localparam logic [CharW-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CharW-1:0] CHAR_NINE = 8'h39;
	localparam logic [CharW-1:0] CHAR_M    = 8'h6D;
	localparam logic [CharW-1:0] CHAR_SEMI = 8'h3B;
	localparam logic [CodeW-1:0] ACCUM_MAX = 10'd999;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_CSI
	} mode_t;

	mode_t             mode_q, mode_d;
	logic [CodeW-1:0]  code_q, code_d;
	logic [ColorW-1:0] color_q, color_d;

	logic              is_digit;
	logic [13:0]       code_x10;

	// Parameter times ten plus the new digit, by shifts and adds
	assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
	assign code_x10 = {1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0} + {10'd0, ch[3:0]};

	// Next state and results for the byte at hand
	always_comb begin
		mode_d  = mode_q;
		code_d  = code_q;
		color_d = color_q;
		push    = '0;
		push.res0.color = color_q;
		push.res1.color = color_q;
		unique case (mode_q)
			MODE_ESC: begin
				if (ch == CHAR_LBRK) begin
					mode_d = MODE_CSI;
					code_d = '0;
				end else begin
					mode_d         = MODE_NORMAL;
					push.cnt       = 2'd2;
					push.res0.ch   = CHAR_ESC;
					push.res0.last = 1'b0;
					push.res1.ch   = ch;
					push.res1.last = 1'b1;
				end
			end
			MODE_CSI: begin
				if (is_digit) begin
					code_d = (code_x10 > {4'd0, ACCUM_MAX}) ? ACCUM_MAX : code_x10[CodeW-1:0];
				end else if (ch == CHAR_M) begin
					color_d = sgr_color(code_q);
					code_d  = '0;
					mode_d  = MODE_NORMAL;
				end else if (ch == CHAR_SEMI) begin
					color_d = sgr_color(code_q);
					code_d  = '0;
				end else begin
					code_d = '0;
					mode_d = MODE_NORMAL;
				end
			end
			default: begin
				if (ch == CHAR_ESC) begin
					mode_d = MODE_ESC;
				end else begin
					mode_d         = MODE_NORMAL;
					push.cnt       = 2'd1;
					push.res0.ch   = ch;
					push.res0.last = 1'b1;
				end
			end
		endcase
	end

	// State registers, updated when a byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			code_q  <= '0;
			color_q <= COLOR_WHITE;
		end else if (fire) begin
			mode_q  <= mode_d;
			code_q  <= code_d;
			color_q <= color_d;
		end
	end

`ifndef SYNTHESIS
	a_code_sat: assert property (@(posedge clk) disable iff (!arst_n)
		code_q <= ACCUM_MAX)
		else $error("SGR parameter above saturation limit");

	a_code_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_CSI) |-> (code_q == '0))
		else $error("SGR parameter not cleared outside CSI");
`endif

endmodule

>>> hw/rtl/asgr_outq.sv
// Two-entry result queue that doubles as the output register.
// Depends on asgr_pkg for the result types.
`timescale 1ns / 1ps

module asgr_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push_valid,
	input  asgr_pkg::asgr_push_t         push,
	output logic [1:0]                   room,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [asgr_pkg::CharW-1:0]   out_char,
	output logic [asgr_pkg::ColorW-1:0]  out_color,
	output logic                         last
);
	import asgr_pkg::*;

	asgr_res_t  q0_q, q1_q, q0_d, q1_d;
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] base;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_char  = q0_q.ch;
	assign out_color = q0_q.color;
	assign last      = q0_q.last;

	// Free slots once this cycle's pop is taken into account
	assign room = 2'd2 - cnt_q + {1'b0, pop};
	assign base = cnt_q - {1'b0, pop};

	// Shift on pop, then append new results behind what remains
	always_comb begin
		q0_d  = pop ? q1_q : q0_q;
		q1_d  = q1_q;
		cnt_d = base + (push_valid ? push.cnt : 2'd0);
		if (push_valid && push.cnt != 2'd0) begin
			if (base == 2'd0) begin
				q0_d = push.res0;
				q1_d = push.res1;
			end else begin
				q1_d = push.res0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		q0_q <= q0_d;
		q1_q <= q1_d;
	end

`ifndef SYNTHESIS
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (push.cnt <= room))
		else $error("result queue overflow");

	a_lone_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> q0_q.last)
		else $error("lone queued result is not the end of its request");

	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q0_q.last) |-> q1_q.last)
		else $error("escape pair split in result queue");
`endif

endmodule

>>> hw/rtl/ansi_sgr_color_parser_top.sv
// Top level of the ANSI SGR color parser: input register, parser, result queue.
// Depends on asgr_pkg, asgr_parser and asgr_outq.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------
//   in      | input     | in_valid / in_stall  | in_char
//   out     | output    | out_valid / out_stall| out_char, out_color, last
//
// One byte is accepted per cycle while in_stall is low; a request yields zero,
// one or two results, which pass the input register and then the result queue.
// Throughput is bounded by the output: a two-result request occupies both
// queue slots, so the input stalls while the queue cannot take its results.
// Reset puts the parser in normal mode with white as the current color.
`timescale 1ns / 1ps

module ansi_sgr_color_parser_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [asgr_pkg::CharW-1:0]   in_char,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [asgr_pkg::CharW-1:0]   out_char,
	output logic [asgr_pkg::ColorW-1:0]  out_color,
	output logic                         last
);
	import asgr_pkg::*;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             adv;
	logic [1:0]       room;
	asgr_push_t       push;

	// The registered byte moves on once the queue has room for its results
	assign adv      = valid_s1 && (push.cnt <= room);
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= in_char;
		end
	end

	asgr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (char_s1),
		.fire   (adv),
		.push   (push)
	);

	asgr_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (adv),
		.push       (push),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.out_color  (out_color),
		.last       (last)
	);

endmodule

>>> tb/sgr_stream_checker.sv
// Stream checker for the ANSI SGR color parser: predicts the glyphs each request
// causes and compares them with the results leaving the block. Depends on asgr_pkg.
`timescale 1ns / 1ps

module sgr_stream_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [asgr_pkg::CharW-1:0]  in_char,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [asgr_pkg::CharW-1:0]  out_char,
	input  logic [asgr_pkg::ColorW-1:0] out_color,
	input  logic                        last,
	output int                          fail_count,
	output int                          glyphs_owed
);
	import asgr_pkg::*;

	typedef enum logic [1:0] {PM_TEXT, PM_ESC, PM_CSI} parse_mode_t;

	localparam logic [CharW-1:0]  CH_ESC      = 8'h1B;
	localparam logic [CharW-1:0]  CH_LBRACKET = 8'h5B;
	localparam logic [CharW-1:0]  CH_SEMI     = 8'h3B;
	localparam logic [CharW-1:0]  CH_M        = 8'h6D;
	localparam logic [CharW-1:0]  CH_ZERO     = 8'h30;
	localparam logic [CharW-1:0]  CH_NINE     = 8'h39;
	localparam logic [ColorW-1:0] WHITE_ARGB  = 32'hFFFF_FFFF;
	localparam int                CODE_CAP    = 999;

	// Shadow of the parser state
	parse_mode_t       mode;
	logic [CodeW-1:0]  code;
	logic [ColorW-1:0] fg;
	asgr_res_t         glyph_q[$];

	// SGR foreground palette; unlisted codes fall back to white
	function automatic logic [ColorW-1:0] palette(input logic [CodeW-1:0] n);
		case (n)
			10'd30:  return 32'hFF11_1111;
			10'd31:  return 32'hFFFF_5555;
			10'd32:  return 32'hFF55_FF55;
			10'd33:  return 32'hFFFF_FF55;
			10'd34:  return 32'hFF55_55FF;
			10'd35:  return 32'hFFFF_55FF;
			10'd36:  return 32'hFF55_FFFF;
			10'd90:  return 32'hFF88_8888;
			10'd91:  return 32'hFFFF_8888;
			10'd92:  return 32'hFF88_FF88;
			10'd93:  return 32'hFFFF_FF88;
			10'd94:  return 32'hFF88_88FF;
			10'd95:  return 32'hFFFF_88FF;
			10'd96:  return 32'hFF88_FFFF;
			default: return WHITE_ARGB;
		endcase
	endfunction

	task automatic queue_glyph(input logic [CharW-1:0] c, input logic fin);
		asgr_res_t g;
		g.ch    = c;
		g.color = fg;
		g.last  = fin;
		glyph_q.push_back(g);
	endtask

	// One parser step for an accepted byte
	task automatic advance_parser(input logic [CharW-1:0] c);
		int acc;
		case (mode)
			PM_ESC: begin
				if (c == CH_LBRACKET) begin
					mode = PM_CSI;
					code = '0;
				end else begin
					// lone ESC is printed, then the byte after it
					mode = PM_TEXT;
					queue_glyph(CH_ESC, 1'b0);
					queue_glyph(c, 1'b1);
				end
			end
			PM_CSI: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					acc  = int'(code) * 10 + int'(c - CH_ZERO);
					code = (acc > CODE_CAP) ? CodeW'(CODE_CAP) : CodeW'(acc);
				end else if (c == CH_M) begin
					fg   = palette(code);
					code = '0;
					mode = PM_TEXT;
				end else if (c == CH_SEMI) begin
					fg   = palette(code);
					code = '0;
				end else begin
					// anything else drops the sequence silently
					code = '0;
					mode = PM_TEXT;
				end
			end
			default: begin
				if (c == CH_ESC) mode = PM_ESC;
				else queue_glyph(c, 1'b1);
			end
		endcase
	endtask

	task automatic report(input string what, input logic [ColorW-1:0] got,
			input logic [ColorW-1:0] want);
		$display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	// Compare leaving results first, then predict for the accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = PM_TEXT;
			code = '0;
			fg   = WHITE_ARGB;
			glyph_q.delete();
			glyphs_owed = 0;
			fail_count  = 0;
		end else begin : watch
			asgr_res_t want;
			if (out_valid && !out_stall) begin
				if (glyph_q.size() == 0) begin
					report("result with no request pending, char",
						ColorW'(out_char), '0);
				end else begin
					want = glyph_q.pop_front();
					if (out_char !== want.ch)
						report("out_char", ColorW'(out_char), ColorW'(want.ch));
					if (out_color !== want.color)
						report("out_color", out_color, want.color);
					if (last !== want.last)
						report("last", ColorW'(last), ColorW'(want.last));
				end
			end
			if (in_valid && !in_stall) advance_parser(in_char);
			glyphs_owed = glyph_q.size();
		end
	end

endmodule

>>> tb/tb_ansi_sgr_color_parser_top.sv
// Testbench top for ansi_sgr_color_parser_top: builds a byte stream of SGR sequences
// and text, drives it in bursts against a stalling receiver. Depends on asgr_pkg and
// sgr_stream_checker.
`timescale 1ns / 1ps

module tb_ansi_sgr_color_parser_top;
	import asgr_pkg::*;

	typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_BUSY} rx_style_t;

	localparam int ITEM_TARGET  = 1050;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_AT      = 600;
	localparam int HOLD_CYCLES  = 400;

	localparam logic [CharW-1:0] CH_ESC      = 8'h1B;
	localparam logic [CharW-1:0] CH_LBRACKET = 8'h5B;
	localparam logic [CharW-1:0] CH_SEMI     = 8'h3B;
	localparam logic [CharW-1:0] CH_M        = 8'h6D;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CharW-1:0]  in_char;
	logic              out_valid;
	logic              out_stall;
	logic [CharW-1:0]  out_char;
	logic [ColorW-1:0] out_color;
	logic              last;
	int                fail_count;
	int                glyphs_owed;

	logic [CharW-1:0]  byte_stream[$];
	int unsigned       known_codes[$] = '{0, 30, 31, 32, 33, 34, 35, 36, 37,
		90, 91, 92, 93, 94, 95, 96, 97};

	ansi_sgr_color_parser_top DUT (.*);

	sgr_stream_checker CHK (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic push(input logic [CharW-1:0] b);
		byte_stream.push_back(b);
	endtask

	task automatic push_number(input int unsigned n);
		string s;
		s = $sformatf("%0d", n);
		foreach (s[i]) push(s[i]);
	endtask

	// Plain text; ESC is kept out so the run stays in normal mode
	task automatic push_text(input int n, input bit printable);
		logic [CharW-1:0] b;
		repeat (n) begin
			if (printable) b = CharW'($urandom_range(32, 126));
			else b = CharW'($urandom_range(0, 255));
			if (b == CH_ESC) b = 8'h1A;
			push(b);
		end
	endtask

	// Well-formed CSI ... m with one to three parameters
	task automatic push_sgr_sequence();
		int nparams;
		int pick;
		push(CH_ESC);
		push(CH_LBRACKET);
		nparams = $urandom_range(1, 3);
		for (int k = 0; k < nparams; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) push_number(known_codes[$urandom_range(0, known_codes.size() - 1)]);
			else if (pick < 85) push_number($urandom_range(0, 199));
			else if (pick >= 95) push_number($urandom_range(1000, 99999));
			if (k < nparams - 1) push(CH_SEMI);
		end
		push(CH_M);
	endtask

	task automatic build_stream();
		int pick;
		// directed: extremes, ESC pairs, color, semicolon, saturation, aborts
		push(8'h00);
		push(CH_ESC); push(CH_ESC);
		push(CH_ESC); push(8'hFF);
		push(CH_ESC); push(CH_LBRACKET); push_number(31); push(CH_M); push("a");
		push(CH_ESC); push(CH_LBRACKET); push_number(96); push(CH_SEMI); push("Q"); push("b");
		push(CH_ESC); push(CH_LBRACKET); push_number(1234); push(CH_M);
		push(CH_ESC); push(CH_LBRACKET); push_number(3); push(CH_ESC); push("d");
		// random: mostly well-formed sequences followed by text
		while (byte_stream.size() < ITEM_TARGET + 30) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				push_sgr_sequence();
				push_text($urandom_range(1, 6), 1'b1);
			end else if (pick < 75) begin
				push_text($urandom_range(1, 8), 1'b0);
			end else if (pick < 85) begin
				push(CH_ESC);
				push(CharW'($urandom_range(0, 255)));
			end else if (pick < 95) begin
				push(CH_ESC);
				push(CH_LBRACKET);
				push_number($urandom_range(0, 120));
				push(CharW'($urandom_range(0, 255)));
			end else begin
				push(CharW'($urandom_range(0, 255)));
			end
		end
	endtask

	// Hold the request until an edge with stall low
	task automatic send_byte(input logic [CharW-1:0] b);
		bit taken;
		in_valid <= 1'b1;
		in_char  <= b;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Sender: bursts with random gaps, then drain and verdict
	initial begin
		int burst;
		int gap;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_char  <= '0;
		build_stream();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (byte_stream.size() > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && byte_stream.size() > 0) begin
				send_byte(byte_stream.pop_front());
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		do @(negedge clk); while (glyphs_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && glyphs_owed == 0) begin
			$display("PASS ansi_sgr_color_parser_top");
		end else begin
			$display("FAIL ansi_sgr_color_parser_top");
		end
		$finish;
	end

	// Receiver: segments of varying stall styles, plus one long hold-off
	initial begin
		int        rx_cycles;
		int        seg_len;
		bit        held;
		rx_style_t style;
		out_stall <= 1'b0;
		rx_cycles = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && rx_cycles >= HOLD_AT) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
					rx_cycles++;
				end
			end
			style   = rx_style_t'($urandom_range(0, 3));
			seg_len = $urandom_range(10, 80);
			repeat (seg_len) begin
				case (style)
					RX_OPEN: out_stall <= 1'b0;
					RX_COIN: out_stall <= ($urandom_range(0, 1) == 1);
					RX_COMB: out_stall <= (rx_cycles % 4 == 3);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
				@(posedge clk);
				rx_cycles++;
			end
		end
	end

	// Watchdog: too long with no handshake on either side
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
			else idle++;
			if (idle >= STALL_LIMIT) begin
				$display("FAIL ansi_sgr_color_parser_top");
				$finish;
			end
		end
	end

endmodule
